// ===== rtl/three_plane_intersection_defines.svh =====
// Assertion macros shared by the plane intersection RTL.
// Depends on nothing; included inside module bodies.
`ifndef THREE_PLANE_INTERSECTION_DEFINES_SVH
`define THREE_PLANE_INTERSECTION_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define TPI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TPI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/tpi_pkg.sv =====
// Package for the three plane intersection block: beat types and constants.
// Depends on nothing.
package tpi_pkg;
    localparam int NORM_FRAC = 14;
    localparam int DET_ALIGN = 12;
    // Fraction bits of the distances, which the coordinates carry over unchanged
    localparam int DIST_FRAC_BITS = 8;
    localparam logic [30:0] DET_MIN_RESET = 31'd1074;
    localparam logic [0:0] ADDR_DET_MIN = 1'b0;
    // Width of the determinant datapath
    localparam int DET_W = 52;

    typedef struct packed {
        logic signed [15:0] n1_x;
        logic signed [15:0] n1_y;
        logic signed [15:0] n1_z;
        logic signed [23:0] d1;
        logic signed [15:0] n2_x;
        logic signed [15:0] n2_y;
        logic signed [15:0] n2_z;
        logic signed [23:0] d2;
        logic signed [15:0] n3_x;
        logic signed [15:0] n3_y;
        logic signed [15:0] n3_z;
        logic signed [23:0] d3;
    } planes_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               point_valid;
    } point_t;
endpackage

// ===== rtl/three_plane_intersection.sv =====
// Three plane intersection by Cramer's rule, pipelined with a restoring divider.
// Pipeline: 3 + 72 + 1 = 76 register stages; one beat per cycle while the output does not stall.
// Three unrolled radix-2 dividers, one stage per quotient bit (72), set the depth.
// The whole pipe advances only while the output register is free or taken.
// rst_n (async, low) clears all valid bits and loads det_min with 1074.
// Depends on tpi_pkg and three_plane_intersection_defines.svh.
module three_plane_intersection (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tpi_pkg::planes_t     in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tpi_pkg::point_t      out_data
);
    import tpi_pkg::*;
    `include "three_plane_intersection_defines.svh"

    // Numerator magnitude bound: 16+16+24 bits product plus sign, plus 14 shift
    localparam int NW = 58 + NORM_FRAC;
    localparam int QB = NW;            // quotient bits produced, one per stage
    localparam int DW = DET_W;

    logic [30:0] det_min_reg;
    logic        adv;
    assign pready = 1'b1;
    assign prdata = {1'b0, det_min_reg};

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            det_min_reg <= DET_MIN_RESET;
        else if (psel && penable && pwrite && paddr[2] == ADDR_DET_MIN && paddr[1:0] == 2'b00)
            det_min_reg <= pwdata[30:0];
    end

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // Stage 1: 2x2 minors
    logic               s1_v_reg;
    logic signed [32:0] m_bc_reg, m_ac_reg, m_ab_reg;
    logic signed [40:0] m_dc_reg, m_db_reg, m_ad_reg, m_bd_reg;
    planes_t            s1_p_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (adv)
            s1_v_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_p_reg <= in_data;
            m_bc_reg <= 33'(in_data.n2_y * in_data.n3_z) - 33'(in_data.n3_y * in_data.n2_z);
            m_ac_reg <= 33'(in_data.n2_x * in_data.n3_z) - 33'(in_data.n3_x * in_data.n2_z);
            m_ab_reg <= 33'(in_data.n2_x * in_data.n3_y) - 33'(in_data.n3_x * in_data.n2_y);
            m_dc_reg <= 41'(in_data.d2 * in_data.n3_z) - 41'(in_data.d3 * in_data.n2_z);
            m_db_reg <= 41'(in_data.d2 * in_data.n3_y) - 41'(in_data.d3 * in_data.n2_y);
            m_ad_reg <= 41'(in_data.n2_x * in_data.d3) - 41'(in_data.n3_x * in_data.d2);
            m_bd_reg <= 41'(in_data.n2_y * in_data.d3) - 41'(in_data.n3_y * in_data.d2);
        end
    end

    // Stage 2: products of first row with minors
    logic               s2_v_reg;
    logic signed [48:0] t_det_reg [3];
    logic signed [57:0] t_nx_reg [3], t_ny_reg [3], t_nz_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (adv)
            s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_det_reg[0] <= 49'(s1_p_reg.n1_x * m_bc_reg);
            t_det_reg[1] <= 49'(s1_p_reg.n1_y * m_ac_reg);
            t_det_reg[2] <= 49'(s1_p_reg.n1_z * m_ab_reg);
            t_nx_reg[0]  <= 58'(s1_p_reg.d1 * m_bc_reg);
            t_nx_reg[1]  <= 58'(s1_p_reg.n1_y * m_dc_reg);
            t_nx_reg[2]  <= 58'(s1_p_reg.n1_z * m_db_reg);
            t_ny_reg[0]  <= 58'(s1_p_reg.n1_x * m_dc_reg);
            t_ny_reg[1]  <= 58'(s1_p_reg.d1 * m_ac_reg);
            t_ny_reg[2]  <= 58'(s1_p_reg.n1_z * m_ad_reg);
            t_nz_reg[0]  <= 58'(s1_p_reg.n1_x * m_bd_reg);
            t_nz_reg[1]  <= 58'(s1_p_reg.n1_y * m_ad_reg);
            t_nz_reg[2]  <= 58'(s1_p_reg.d1 * m_ab_reg);
        end
    end

    // Stage 3: sums, magnitudes and threshold test
    logic            s3_v_reg, s3_ok_reg;
    logic [DW-1:0]   s3_den_reg;
    logic [58:0]     s3_num_reg [3];
    logic [2:0]      s3_neg_reg;
    logic signed [DW-1:0] det_w;
    logic signed [59:0]   n_w [3];
    logic [DW-1:0]   dmag_w;
    assign det_w  = DW'(t_det_reg[0]) - DW'(t_det_reg[1]) + DW'(t_det_reg[2]);
    assign n_w[0] = 60'(t_nx_reg[0]) - 60'(t_nx_reg[1]) + 60'(t_nx_reg[2]);
    assign n_w[1] = 60'(t_ny_reg[0]) - 60'(t_ny_reg[1]) + 60'(t_ny_reg[2]);
    assign n_w[2] = 60'(t_nz_reg[0]) - 60'(t_nz_reg[1]) + 60'(t_nz_reg[2]);
    assign dmag_w = det_w[DW-1] ? DW'(-det_w) : DW'(det_w);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (adv)
            s3_v_reg <= s2_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_den_reg <= dmag_w;
            s3_ok_reg  <= (dmag_w != '0) &&
                          !(dmag_w < ({(DW - 31)'(0), det_min_reg} << DET_ALIGN));
            for (int i = 0; i < 3; i++)
            begin
                s3_num_reg[i] <= n_w[i][59] ? 59'(-n_w[i]) : 59'(n_w[i]);
                s3_neg_reg[i] <= n_w[i][59] != det_w[DW-1];
            end
        end
    end

    // Divider pipeline: one quotient bit per stage, restoring
    localparam int DEP = QB;
    logic            dv_v_reg   [DEP];
    logic            dv_ok_reg  [DEP];
    logic [DW-1:0]   dv_den_reg [DEP];
    logic [2:0]      dv_neg_reg [DEP];
    logic [NW-1:0]   dv_num_reg [DEP][3];
    logic [DW:0]     dv_rem_reg [DEP][3];
    logic [QB-1:0]   dv_q_reg   [DEP][3];
    logic            dv_v_w     [DEP];
    logic            dv_ok_w    [DEP];
    logic [DW-1:0]   dv_den_w   [DEP];
    logic [2:0]      dv_neg_w   [DEP];
    logic [NW-1:0]   dv_num_w   [DEP][3];
    logic [DW:0]     dv_rem_w   [DEP][3];
    logic [QB-1:0]   dv_q_w     [DEP][3];
    logic [DW+1:0]   dv_sh_w    [DEP][3];

    // Stage inputs: the threshold stage feeds the first divider stage
    always_comb
    begin
        dv_v_w[0]   = s3_v_reg;
        dv_ok_w[0]  = s3_ok_reg;
        dv_den_w[0] = s3_den_reg;
        dv_neg_w[0] = s3_neg_reg;
        for (int i = 0; i < 3; i++)
        begin
            dv_num_w[0][i] = {13'd0, s3_num_reg[i]} << NORM_FRAC;
            dv_rem_w[0][i] = '0;
            dv_q_w[0][i]   = '0;
        end
        for (int k = 1; k < DEP; k++)
        begin
            dv_v_w[k]   = dv_v_reg[k-1];
            dv_ok_w[k]  = dv_ok_reg[k-1];
            dv_den_w[k] = dv_den_reg[k-1];
            dv_neg_w[k] = dv_neg_reg[k-1];
            for (int i = 0; i < 3; i++)
            begin
                dv_num_w[k][i] = dv_num_reg[k-1][i];
                dv_rem_w[k][i] = dv_rem_reg[k-1][i];
                dv_q_w[k][i]   = dv_q_reg[k-1][i];
            end
        end
        for (int k = 0; k < DEP; k++)
        begin
            for (int i = 0; i < 3; i++)
                dv_sh_w[k][i] = {dv_rem_w[k][i], dv_num_w[k][i][NW-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEP; k++)
                dv_v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k < DEP; k++)
                dv_v_reg[k] <= dv_v_w[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DEP; k++)
            begin
                dv_ok_reg[k]  <= dv_ok_w[k];
                dv_den_reg[k] <= dv_den_w[k];
                dv_neg_reg[k] <= dv_neg_w[k];
                for (int i = 0; i < 3; i++)
                begin
                    dv_num_reg[k][i] <= dv_num_w[k][i] << 1;
                    if (dv_sh_w[k][i] >= {2'b00, dv_den_w[k]})
                    begin
                        dv_rem_reg[k][i] <= (DW+1)'(dv_sh_w[k][i] - {2'b00, dv_den_w[k]});
                        dv_q_reg[k][i]   <= {dv_q_w[k][i][QB-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[k][i] <= (DW+1)'(dv_sh_w[k][i]);
                        dv_q_reg[k][i]   <= {dv_q_w[k][i][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Final stage: round, saturate, sign
    point_t        res_w;
    logic          out_valid_reg;
    point_t        out_data_reg;
    logic [31:0]   coord_w [3];
    always_comb
    begin
        logic [QB:0] q;
        logic [QB:0] lim;
        for (int i = 0; i < 3; i++)
        begin
            q = {1'b0, dv_q_reg[DEP-1][i]};
            if ({dv_rem_reg[DEP-1][i], 1'b0} >= {1'b0, dv_den_reg[DEP-1]})
                q = q + 1'b1;
            lim = dv_neg_reg[DEP-1][i] ? (QB+1)'(64'h8000_0000) : (QB+1)'(64'h7FFF_FFFF);
            if (q > lim)
                q = lim;
            coord_w[i] = dv_neg_reg[DEP-1][i] ? 32'(-q) : 32'(q);
        end
        res_w.point_valid = dv_ok_reg[DEP-1];
        res_w.point_x = dv_ok_reg[DEP-1] ? coord_w[0] : '0;
        res_w.point_y = dv_ok_reg[DEP-1] ? coord_w[1] : '0;
        res_w.point_z = dv_ok_reg[DEP-1] ? coord_w[2] : '0;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_v_reg[DEP-1];
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= res_w;
    end
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `TPI_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, out_valid && out_stall, "stall without full output")
    `TPI_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_valid && !out_data.point_valid, out_data.point_x == 0 && out_data.point_y == 0 && out_data.point_z == 0, "degenerate result not zero")
    `TPI_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "held beat changed")
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for three_plane_intersection: Cramer's rule solver.
// Depends on tpi_pkg and the block's RTL; carries its own exact predictor.
module tb;
    import tpi_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [2:0] DET_MIN_ADDR = {ADDR_DET_MIN, 2'b00};
    localparam logic [2:0] SPARE_ADDR = 3'd4;
    localparam logic signed [15:0] ONE = 16'sd16384;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    planes_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    point_t out_data;

    // predictor copy of the threshold register
    logic [30:0] det_min_shadow = DET_MIN_RESET;
    point_t expected_points[$];
    int mismatches = 0;
    int cycles = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    three_plane_intersection u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall: random, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // numerator * 2^14 / den, nearest with ties away from zero, saturated
    function automatic logic signed [31:0] scaled_quotient(longint num, longint den);
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        logic [127:0] r;
        logic neg;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? 128'(-num) : 128'(num);
        ud = (den < 0) ? 128'(-den) : 128'(den);
        un = un << NORM_FRAC;
        q = un / ud;
        r = un % ud;
        if ((r << 1) >= ud)
            q = q + 1;
        if (neg)
        begin
            if (q > 128'h8000_0000)
                q = 128'h8000_0000;
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF)
            q = 128'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic point_t solve_planes(planes_t p);
        longint a1, b1, c1, d1, a2, b2, c2, d2, a3, b3, c3, d3;
        longint det, nx, ny, nz, mag;
        point_t pt;
        a1 = $signed(p.n1_x); b1 = $signed(p.n1_y); c1 = $signed(p.n1_z);
        a2 = $signed(p.n2_x); b2 = $signed(p.n2_y); c2 = $signed(p.n2_z);
        a3 = $signed(p.n3_x); b3 = $signed(p.n3_y); c3 = $signed(p.n3_z);
        d1 = $signed(p.d1); d2 = $signed(p.d2); d3 = $signed(p.d3);
        det = a1 * (b2 * c3 - b3 * c2) - b1 * (a2 * c3 - a3 * c2)
            + c1 * (a2 * b3 - a3 * b2);
        mag = (det < 0) ? -det : det;
        pt = '0;
        if (det == 0 || mag < (longint'(det_min_shadow) << DET_ALIGN))
            return pt;
        nx = d1 * (b2 * c3 - b3 * c2) - b1 * (d2 * c3 - d3 * c2)
           + c1 * (d2 * b3 - d3 * b2);
        ny = a1 * (d2 * c3 - d3 * c2) - d1 * (a2 * c3 - a3 * c2)
           + c1 * (a2 * d3 - a3 * d2);
        nz = a1 * (b2 * d3 - b3 * d2) - b1 * (a2 * d3 - a3 * d2)
           + d1 * (a2 * b3 - a3 * b2);
        pt.point_x = scaled_quotient(nx, det);
        pt.point_y = scaled_quotient(ny, det);
        pt.point_z = scaled_quotient(nz, det);
        pt.point_valid = 1'b1;
        return pt;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("point mismatch on %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
                report_mismatch("unexpected beat", 32'(out_data.point_valid), 32'd0);
            else
            begin
                want = expected_points.pop_front();
                if (out_data.point_valid !== want.point_valid)
                    report_mismatch("point_valid", 32'(out_data.point_valid),
                                    32'(want.point_valid));
                if (out_data.point_x !== want.point_x)
                    report_mismatch("point_x", out_data.point_x, want.point_x);
                if (out_data.point_y !== want.point_y)
                    report_mismatch("point_y", out_data.point_y, want.point_y);
                if (out_data.point_z !== want.point_z)
                    report_mismatch("point_z", out_data.point_z, want.point_z);
            end
        end
    end

    task automatic send_planes(planes_t p);
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_points.push_back(solve_planes(p));
        // sender inserts idle gaps at the configured percentage
        while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[2] == ADDR_DET_MIN)
            det_min_shadow = value[30:0];
    endtask

    function automatic planes_t axis_planes(logic signed [15:0] s, logic signed [23:0] d1,
                                            logic signed [23:0] d2, logic signed [23:0] d3);
        planes_t p;
        p = '0;
        p.n1_x = s; p.n2_y = s; p.n3_z = s;
        p.d1 = d1; p.d2 = d2; p.d3 = d3;
        return p;
    endfunction

    function automatic logic signed [15:0] random_normal();
        if ($urandom_range(99) < 85)
            return 16'($signed($urandom_range(32768)) - 16384);
        return 16'($urandom);
    endfunction

    function automatic planes_t random_planes();
        planes_t p;
        p.n1_x = random_normal(); p.n1_y = random_normal(); p.n1_z = random_normal();
        p.n2_x = random_normal(); p.n2_y = random_normal(); p.n2_z = random_normal();
        p.n3_x = random_normal(); p.n3_y = random_normal(); p.n3_z = random_normal();
        p.d1 = 24'($urandom); p.d2 = 24'($urandom); p.d3 = 24'($urandom);
        case ($urandom_range(9))
            0: begin p.n3_x = p.n1_x; p.n3_y = p.n1_y; p.n3_z = p.n1_z; end
            1: begin p.n2_x = '0; p.n2_y = '0; p.n2_z = '0; end
            2: begin p.n1_x = 16'($urandom_range(3)); p.n2_y = 16'($urandom_range(3)); end
            default: ;
        endcase
        return p;
    endfunction

    // extremes of the fields, degenerate and saturating systems
    task automatic test_directed;
        planes_t p;
        send_planes(axis_planes(ONE, 24'sd256, -24'sd256, 24'sd0));
        send_planes(axis_planes(ONE, 24'h7FFFFF, 24'h800000, 24'h000001));
        send_planes(axis_planes(-ONE, 24'h7FFFFF, 24'h800000, 24'hFFFFFF));
        send_planes(axis_planes(16'sh8000, 24'h800000, 24'h7FFFFF, 24'h123456));
        send_planes(axis_planes(16'sh7FFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000));
        // tiny determinant with huge distances: below the threshold, so the result is zero
        send_planes(axis_planes(16'sd64, 24'h7FFFFF, 24'h800000, 24'h7FFFFF));
        send_planes(axis_planes(16'sd1, 24'h7FFFFF, 24'h800000, 24'h000003));
        send_planes('0);
        p = axis_planes(ONE, 24'sd100, 24'sd200, 24'sd300);
        p.n3_x = ONE; p.n3_z = 16'sd0;
        send_planes(p);
        p = axis_planes(ONE, 24'sd77, 24'sd9, -24'sd5);
        p.n1_y = 16'sd11585; p.n1_x = 16'sd11585; p.n2_z = -16'sd9000;
        send_planes(p);
        p = '1;
        send_planes(p);
        p = '0;
        p.n1_x = 16'sh8000; p.n1_y = 16'sh7FFF; p.n2_y = 16'sh8000;
        p.n2_z = 16'sh7FFF; p.n3_z = 16'sh8000; p.n3_x = 16'sh7FFF;
        p.d1 = 24'h800000; p.d2 = 24'h7FFFFF; p.d3 = 24'h555555;
        send_planes(p);
        drain();
    endtask

    // threshold register at its extremes, plus a write to an unused address
    task automatic test_threshold;
        logic [31:0] settings [4] = '{32'd0, 32'd1073741824, 32'hFFFF_FFFF, 32'd262144};
        foreach (settings[i])
        begin
            write_reg(DET_MIN_ADDR, settings[i]);
            send_planes(axis_planes(ONE, 24'sd512, -24'sd512, 24'sd1));
            send_planes(axis_planes(16'sd16383, 24'sd512, -24'sd512, 24'sd1));
            send_planes(axis_planes(16'sd1, 24'sd3, 24'sd1, 24'sd2));
            repeat (12) send_planes(random_planes());
            drain();
        end
        write_reg(SPARE_ADDR, 32'd5);
        write_reg(DET_MIN_ADDR, 32'(DET_MIN_RESET));
        send_planes(axis_planes(ONE, 24'sd1, 24'sd2, 24'sd3));
        drain();
    endtask

    task automatic test_random(int gap_pct, int stall_pct, int count);
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_planes(random_planes());
        drain();
    endtask

    // long receiver hold-off while the sender keeps offering beats
    task automatic test_backpressure;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        hold_request = 400;
        repeat (150) send_planes(random_planes());
        drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_threshold();
        test_random(21, 51, 450);
        test_backpressure();
        write_reg(DET_MIN_ADDR, 32'd1000000);
        test_random(51, 21, 400);
        write_reg(DET_MIN_ADDR, 32'(DET_MIN_RESET));
        test_random(0, 0, 400);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
